// ===== src/bgd_pkg.sv =====
package bgd_pkg;

    typedef enum logic [6:0] {
        PH_IDLE     = 7'b0000001,
        PH_PRESSED1 = 7'b0000010,
        PH_PAUSE1   = 7'b0000100,
        PH_PRESSED2 = 7'b0001000,
        PH_PAUSE2   = 7'b0010000,
        PH_PRESSED3 = 7'b0100000,
        PH_LONG     = 7'b1000000
    } t_phase;

    typedef enum logic [3:0] {
        EV_SINGLE    = 4'd0,
        EV_DOUBLE    = 4'd1,
        EV_TRIPLE    = 4'd2,
        EV_PRESSED   = 4'd3,
        EV_RELEASED  = 4'd4,
        EV_VERY_LONG = 4'd5,
        EV_TRIGGER   = 4'd6,
        EV_ON        = 4'd7,
        EV_OFF       = 4'd8
    } t_event;

    localparam logic [1:0] ST_TOGGLE    = 2'd0;
    localparam logic [1:0] ST_MOMENTARY = 2'd1;
    localparam logic [1:0] ST_MULTI     = 2'd2;

    localparam logic [2:0] MODE_FRONT  = 3'd0;
    localparam logic [2:0] MODE_SINGLE = 3'd1;
    localparam logic [2:0] MODE_DOUBLE = 3'd2;
    localparam logic [2:0] MODE_TRIPLE = 3'd3;
    localparam logic [2:0] MODE_LONG   = 3'd4;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_SWITCH_TYPE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SWITCH_MODE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_PAUSE   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LONG_TICKS  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_VLONG_TICKS = 3'd4;

    localparam logic [15:0] RST_MAX_PAUSE   = 16'd30;
    localparam logic [15:0] RST_LONG_TICKS  = 16'd100;
    localparam logic [15:0] RST_VLONG_TICKS = 16'd500;

    localparam int SETTLE_TICKS = 2;
    localparam int MAX_EVENTS   = 3;

    localparam int EVQ_DEPTH = 8;
    localparam int EVQ_AW    = 3;
    localparam int EVQ_CW    = 4;

    typedef struct packed {
        logic [1:0]  switch_type;
        logic [2:0]  switch_mode;
        logic [15:0] max_pause;
        logic [15:0] long_press_ticks;
        logic [15:0] very_long_ticks;
    } t_cfg;

    typedef struct packed {
        logic [1:0]                cnt;
        t_event [MAX_EVENTS-1:0]   evs;
    } t_evlist;

endpackage

// ===== src/bgd_step.sv =====
module bgd_step #(
    parameter int TICK_COUNT_WIDTH = 16
) (
    input  bgd_pkg::t_phase              i_phase,
    input  logic [TICK_COUNT_WIDTH-1:0]  i_ticks,
    input  logic                         i_pressed,
    input  bgd_pkg::t_cfg                i_cfg,
    output bgd_pkg::t_phase              o_phase,
    output logic [TICK_COUNT_WIDTH-1:0]  o_ticks,
    output bgd_pkg::t_evlist             o_res
);
    import bgd_pkg::*;

    localparam int CW = (TICK_COUNT_WIDTH > 16) ? TICK_COUNT_WIDTH : 16;

    logic [TICK_COUNT_WIDTH-1:0] ticks_inc;
    logic [CW-1:0]               ticks_x;
    logic                        settled;
    logic                        over_long;
    logic                        over_pause;
    logic                        over_vlong;
    logic                        gone;
    logic                        vl_hit;
    logic [1:0]                  m_cnt;
    t_event                      m0;
    t_event                      m1;
    t_phase                      phase_n;
    logic                        p;

    always_comb begin
        p          = i_pressed;
        ticks_inc  = (&i_ticks) ? i_ticks : i_ticks + 1'b1;
        ticks_x    = CW'(ticks_inc);
        settled    = ticks_inc >= TICK_COUNT_WIDTH'(SETTLE_TICKS);
        over_long  = ticks_x > CW'(i_cfg.long_press_ticks);
        over_pause = ticks_x > CW'(i_cfg.max_pause);
        over_vlong = ticks_x > CW'(i_cfg.very_long_ticks);

        phase_n = i_phase;
        gone    = 1'b0;
        m_cnt   = 2'd0;
        m0      = EV_SINGLE;
        m1      = EV_SINGLE;

        if (settled) begin
            case (i_cfg.switch_type)
                ST_TOGGLE: begin
                    unique case (i_phase)
                        PH_IDLE: begin
                            if (p) begin
                                phase_n = PH_PRESSED1;
                                gone    = 1'b1;
                                m0      = EV_SINGLE;
                                m_cnt   = 2'd1;
                                if (i_cfg.switch_mode == MODE_FRONT) begin
                                    m1    = EV_TRIGGER;
                                    m_cnt = 2'd2;
                                end
                            end
                        end
                        PH_PRESSED1: begin
                            if (!p) begin
                                phase_n = PH_IDLE;
                                gone    = 1'b1;
                            end
                        end
                        default: begin
                            phase_n = PH_IDLE;
                            gone    = 1'b1;
                        end
                    endcase
                end
                ST_MOMENTARY: begin
                    unique case (i_phase)
                        PH_IDLE: begin
                            if (p) begin
                                phase_n = PH_PRESSED1;
                                gone    = 1'b1;
                                m0      = EV_PRESSED;
                                m_cnt   = 2'd1;
                                if (i_cfg.switch_mode == MODE_FRONT) begin
                                    m1    = EV_ON;
                                    m_cnt = 2'd2;
                                end
                            end
                        end
                        PH_PRESSED1: begin
                            if (!p) begin
                                phase_n = PH_IDLE;
                                gone    = 1'b1;
                                m0      = EV_RELEASED;
                                m_cnt   = 2'd1;
                                if (i_cfg.switch_mode == MODE_FRONT) begin
                                    m1    = EV_OFF;
                                    m_cnt = 2'd2;
                                end
                            end
                        end
                        default: begin
                            phase_n = PH_IDLE;
                            gone    = 1'b1;
                        end
                    endcase
                end
                ST_MULTI: begin
                    unique case (i_phase)
                        PH_IDLE: begin
                            if (p) begin
                                phase_n = PH_PRESSED1;
                                gone    = 1'b1;
                                if (i_cfg.switch_mode == MODE_FRONT) begin
                                    m0    = EV_TRIGGER;
                                    m_cnt = 2'd1;
                                end
                            end
                        end
                        PH_PRESSED1: begin
                            if (p) begin
                                if (over_long) begin
                                    phase_n = PH_LONG;
                                    gone    = 1'b1;
                                    m0      = EV_PRESSED;
                                    m_cnt   = 2'd1;
                                    if (i_cfg.switch_mode == MODE_LONG) begin
                                        m1    = EV_TRIGGER;
                                        m_cnt = 2'd2;
                                    end
                                end
                            end else begin
                                phase_n = PH_PAUSE1;
                                gone    = 1'b1;
                            end
                        end
                        PH_PAUSE1: begin
                            if (p) begin
                                phase_n = PH_PRESSED2;
                                gone    = 1'b1;
                            end else if (over_pause) begin
                                phase_n = PH_IDLE;
                                gone    = 1'b1;
                                m0      = EV_SINGLE;
                                m_cnt   = 2'd1;
                                if (i_cfg.switch_mode == MODE_SINGLE) begin
                                    m1    = EV_TRIGGER;
                                    m_cnt = 2'd2;
                                end
                            end
                        end
                        PH_PRESSED2: begin
                            if (!p) begin
                                phase_n = PH_PAUSE2;
                                gone    = 1'b1;
                            end
                        end
                        PH_PAUSE2: begin
                            if (p) begin
                                phase_n = PH_PRESSED3;
                                gone    = 1'b1;
                            end else if (over_pause) begin
                                phase_n = PH_IDLE;
                                gone    = 1'b1;
                                m0      = EV_DOUBLE;
                                m_cnt   = 2'd1;
                                if (i_cfg.switch_mode == MODE_DOUBLE) begin
                                    m1    = EV_TRIGGER;
                                    m_cnt = 2'd2;
                                end
                            end
                        end
                        PH_PRESSED3: begin
                            if (!p) begin
                                phase_n = PH_IDLE;
                                gone    = 1'b1;
                                if (i_cfg.switch_mode == MODE_TRIPLE) begin
                                    m0    = EV_TRIGGER;
                                    m1    = EV_TRIPLE;
                                    m_cnt = 2'd2;
                                end else begin
                                    m0    = EV_TRIPLE;
                                    m_cnt = 2'd1;
                                end
                            end
                        end
                        PH_LONG: begin
                            if (!p) begin
                                phase_n = PH_IDLE;
                                gone    = 1'b1;
                                m0      = EV_RELEASED;
                                m_cnt   = 2'd1;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
                default: begin
                end
            endcase
        end

        // counter is zero after a phase change, so the check can only hit without one
        vl_hit = p && !gone && over_vlong;

        o_phase = vl_hit ? PH_IDLE : phase_n;
        o_ticks = (vl_hit || gone) ? '0 : ticks_inc;

        o_res.evs[0] = m0;
        o_res.evs[1] = m1;
        o_res.evs[2] = m1;
        if (vl_hit) begin
            case (m_cnt)
                2'd0:    o_res.evs[0] = EV_VERY_LONG;
                2'd1:    o_res.evs[1] = EV_VERY_LONG;
                default: o_res.evs[2] = EV_VERY_LONG;
            endcase
        end
        o_res.cnt = m_cnt + 2'(vl_hit);
    end

endmodule

// ===== src/bgd_evq.sv =====
module bgd_evq (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  bgd_pkg::t_evlist  i_wr,
    input  logic              i_rd,
    output logic              o_valid,
    output bgd_pkg::t_event   o_event,
    output logic              o_last,
    output logic              o_full
);
    import bgd_pkg::*;

    t_event              r_ev  [EVQ_DEPTH];
    logic                r_lst [EVQ_DEPTH];
    logic [EVQ_AW-1:0]   r_wp;
    logic [EVQ_AW-1:0]   r_rp;
    logic [EVQ_CW-1:0]   r_cnt;
    logic                rd;

    assign o_valid = r_cnt != '0;
    assign rd      = i_rd && o_valid;
    assign o_event = r_ev[r_rp];
    assign o_last  = r_lst[r_rp];
    // room must remain for a full tick's worth of events
    assign o_full  = r_cnt > EVQ_CW'(EVQ_DEPTH - MAX_EVENTS);

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < MAX_EVENTS; k++) begin
            if (2'(k) < i_wr.cnt) begin
                r_ev[r_wp + EVQ_AW'(k)]  <= i_wr.evs[k];
                r_lst[r_wp + EVQ_AW'(k)] <= 2'(k) == (i_wr.cnt - 2'd1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= r_wp + EVQ_AW'(i_wr.cnt);
            r_rp  <= r_rp + EVQ_AW'(rd);
            r_cnt <= r_cnt + EVQ_CW'(i_wr.cnt) - EVQ_CW'(rd);
        end
    end

endmodule

// ===== src/button_gesture_detector_core.sv =====
// Accepted ticks write their events to the queue; o_valid offers them in order.
// Throughput: one tick per cycle; the input stalls only while the 8-entry event queue
// has fewer than 3 free entries. Events leave the queue one per cycle unless i_stall.
// Reset (synchronous, active low): phase idle, tick counter zero, queue empty,
// registers at 0, 0, 30, 100, 500.
module button_gesture_detector_core #(
    parameter int TICK_COUNT_WIDTH = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic                              i_pressed,
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic [3:0]                        o_event_res,
    output logic                              o_last,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [bgd_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [bgd_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    import bgd_pkg::*;

    t_cfg                         r_cfg;
    t_phase                       r_phase;
    logic [TICK_COUNT_WIDTH-1:0]  r_ticks;
    t_phase                       n_phase;
    logic [TICK_COUNT_WIDTH-1:0]  n_ticks;
    t_evlist                      step_res;
    t_evlist                      wr;
    t_event                       q_event;
    logic                         acc;
    logic                         q_full;

    assign o_cfg_ready = 1'b1;
    assign o_stall     = q_full;
    assign acc         = i_valid && !q_full;
    assign o_event_res = q_event;

    always_comb begin
        wr = step_res;
        if (!acc) begin
            wr.cnt = 2'd0;
        end
    end

    bgd_step #(
        .TICK_COUNT_WIDTH(TICK_COUNT_WIDTH)
    ) u_step (
        .i_phase   (r_phase),
        .i_ticks   (r_ticks),
        .i_pressed (i_pressed),
        .i_cfg     (r_cfg),
        .o_phase   (n_phase),
        .o_ticks   (n_ticks),
        .o_res     (step_res)
    );

    bgd_evq u_evq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (wr),
        .i_rd    (!i_stall),
        .o_valid (o_valid),
        .o_event (q_event),
        .o_last  (o_last),
        .o_full  (q_full)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_ticks <= '0;
        end else if (acc) begin
            r_phase <= n_phase;
            r_ticks <= n_ticks;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.switch_type      <= ST_TOGGLE;
            r_cfg.switch_mode      <= MODE_FRONT;
            r_cfg.max_pause        <= RST_MAX_PAUSE;
            r_cfg.long_press_ticks <= RST_LONG_TICKS;
            r_cfg.very_long_ticks  <= RST_VLONG_TICKS;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_SWITCH_TYPE: r_cfg.switch_type      <= i_cfg_data[1:0];
                REG_SWITCH_MODE: r_cfg.switch_mode      <= i_cfg_data[2:0];
                REG_MAX_PAUSE:   r_cfg.max_pause        <= i_cfg_data;
                REG_LONG_TICKS:  r_cfg.long_press_ticks <= i_cfg_data;
                REG_VLONG_TICKS: r_cfg.very_long_ticks  <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

endmodule
